// ===== hw/rtl/frac_pkg.sv =====
package frac_pkg;

  // Entries in the queue between the front and the back part.
  localparam int QUEUE_DEPTH = 2;

  // What the back part has to do with a queued request.
  localparam logic KIND_DIRECT = 1'b0;
  localparam logic KIND_REDUCE = 1'b1;

  // Bytes-aligned width of a bus that carries the given number of bits.
  function automatic int bus_bits(input int bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

// ===== hw/rtl/fraction_reducer_unit.sv =====
// Fraction reducer: takes an unsigned numerator and denominator and returns
// the fraction in lowest terms, one result for every request.
// The input channel (in_*) carries the fraction, the output channel (out_*)
// the reduced fraction, both in the same packing of tdata.
// Denominator one, zero numerator and equal parts are settled as a request
// is taken in; such a request passes through the queue and is then offered
// from the output register.
// Any other fraction goes through a binary GCD unit, one step per cycle, and
// then through two restoring dividers working side by side, one quotient bit
// per cycle. The block works on one fraction at a time; a small queue in front
// still takes up to two further requests while one is being reduced.
// A finished result waits in the output register while out_tready is low;
// the block then takes no new work from its queue, and in_tready falls once
// the queue fills. Reset empties the queue and drops any pending result.
module fraction_reducer_unit import frac_pkg::*; #(
  parameter int WIDTH = 64,
  localparam int DataW = bus_bits(2 * WIDTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [DataW-1:0] in_tdata,   // numerator_in, denominator_in, zero fill
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [DataW-1:0] out_tdata   // reduced_numerator, reduced_denominator, zero fill
);

  localparam int QW = 2 * WIDTH + 1;

  logic             q_push, q_full, q_pop, q_valid;
  logic [QW-1:0]    q_wdata, q_rdata;
  logic [WIDTH-1:0] res_num, res_den;

  frac_front #(.WIDTH(WIDTH)) u_front (
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .numerator_in   (in_tdata[WIDTH-1:0]),
    .denominator_in (in_tdata[2*WIDTH-1:WIDTH]),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  frac_queue #(.DW(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_rdata)
  );

  frac_back #(.WIDTH(WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_num   (res_num),
    .out_den   (res_den)
  );

  assign out_tdata = DataW'({res_den, res_num});

endmodule

// ===== hw/rtl/frac_front.sv =====
module frac_front import frac_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [WIDTH-1:0]   numerator_in,
  input  logic [WIDTH-1:0]   denominator_in,
  input  logic               q_full,
  output logic               q_push,
  output logic [2*WIDTH:0]   q_data       // num, den, kind from the lowest bit up
);

  localparam logic [WIDTH-1:0] One = WIDTH'(1);

  logic             kind;
  logic [WIDTH-1:0] num_c;
  logic [WIDTH-1:0] den_c;

  // The special cases are settled here, so the back part runs the divisor
  // search only for fractions marked KIND_REDUCE.
  always_comb begin
    kind  = KIND_DIRECT;
    num_c = numerator_in;
    den_c = denominator_in;
    if (denominator_in == One) begin
      kind = KIND_DIRECT;
    end else if (numerator_in == '0) begin
      den_c = (denominator_in != '0) ? One : '0;
    end else if (numerator_in == denominator_in) begin
      num_c = One;
      den_c = One;
    end else begin
      kind = KIND_REDUCE;
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign q_data    = {kind, den_c, num_c};

endmodule

// ===== hw/rtl/frac_queue.sv =====
module frac_queue import frac_pkg::*; #(
  parameter int DW = 129
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output logic [DW-1:0] pop_data
);

  localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(QUEUE_DEPTH - 1);

  logic [DW-1:0]   mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign full      = (count_r == CNTW'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/frac_back.sv =====
module frac_back import frac_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  logic [2*WIDTH:0] q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_num,
  output logic [WIDTH-1:0] out_den
);

  localparam int KW = $clog2(WIDTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_GCD  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [WIDTH-1:0] a_r, a_nxt, b_r, b_nxt, g_r, g_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [KW-1:0]    cnt_r, cnt_nxt;
  logic [WIDTH-1:0] num_r, num_nxt, den_r, den_nxt;
  logic [WIDTH-1:0] rem_n_r, rem_n_nxt, rem_d_r, rem_d_nxt;
  logic [WIDTH-1:0] out_num_r, out_num_nxt, out_den_r, out_den_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             out_free;
  logic             q_kind;
  logic [WIDTH-1:0] q_num, q_den;
  logic [WIDTH:0]   sh_n, sh_d, g_ext;
  logic             ge_n, ge_d;

  assign q_kind = q_data[2*WIDTH];
  assign q_den  = q_data[2*WIDTH-1:WIDTH];
  assign q_num  = q_data[WIDTH-1:0];

  assign out_free = !out_valid_r || out_ready;

  // One step of each restoring divider; both share the divisor.
  assign g_ext = {1'b0, g_r};
  assign sh_n  = {rem_n_r, num_r[WIDTH-1]};
  assign sh_d  = {rem_d_r, den_r[WIDTH-1]};
  assign ge_n  = (sh_n >= g_ext);
  assign ge_d  = (sh_d >= g_ext);

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    g_nxt         = g_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    rem_n_nxt     = rem_n_r;
    rem_d_nxt     = rem_d_r;
    out_num_nxt   = out_num_r;
    out_den_nxt   = out_den_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (q_kind == KIND_DIRECT) begin
            out_num_nxt   = q_num;
            out_den_nxt   = q_den;
            out_valid_nxt = 1'b1;
          end else begin
            a_nxt     = q_num;
            b_nxt     = q_den;
            num_nxt   = q_num;
            den_nxt   = q_den;
            k_nxt     = '0;
            state_nxt = S_GCD;
          end
        end
      end
      S_GCD: begin
        // Binary GCD, one step per cycle; k counts the common factors of two.
        cnt_nxt   = '0;
        rem_n_nxt = '0;
        rem_d_nxt = '0;
        if (a_r == '0) begin
          g_nxt     = b_r << k_r;
          state_nxt = S_DIV;
        end else if (b_r == '0) begin
          g_nxt     = a_r << k_r;
          state_nxt = S_DIV;
        end else if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (a_r >= b_r) begin
          a_nxt = (a_r - b_r) >> 1;
        end else begin
          b_nxt = (b_r - a_r) >> 1;
        end
      end
      S_DIV: begin
        num_nxt   = {num_r[WIDTH-2:0], ge_n};
        den_nxt   = {den_r[WIDTH-2:0], ge_d};
        rem_n_nxt = ge_n ? WIDTH'(sh_n - g_ext) : sh_n[WIDTH-1:0];
        rem_d_nxt = ge_d ? WIDTH'(sh_d - g_ext) : sh_d[WIDTH-1:0];
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == KW'(WIDTH - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_num_nxt   = num_r;
          out_den_nxt   = den_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    g_r       <= g_nxt;
    k_r       <= k_nxt;
    cnt_r     <= cnt_nxt;
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    rem_n_r   <= rem_n_nxt;
    rem_d_r   <= rem_d_nxt;
    out_num_r <= out_num_nxt;
    out_den_r <= out_den_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_num   = out_num_r;
  assign out_den   = out_den_r;

endmodule

// ===== dv/tb_fraction_reducer_unit.sv =====
`timescale 1ns / 100ps

module tb_fraction_reducer_unit;
  import frac_pkg::*;

  localparam int WIDTH = 64;
  localparam int DATA_W = bus_bits(2 * WIDTH);
  localparam int TABLE_ROWS = 22;
  localparam int RANDOM_PER_PHASE = 500;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 3 * WIDTH + 3 + 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam bit [WIDTH-1:0] ALL_ONES = '1;
  localparam bit [WIDTH-1:0] TOP_BIT = {1'b1, {(WIDTH - 1){1'b0}}};

  // Packed so that the numerator lands in the low half of tdata.
  typedef struct packed {
    bit [WIDTH-1:0] den;
    bit [WIDTH-1:0] num;
  } fraction_t;

  typedef struct {
    bit [WIDTH-1:0] num;
    bit [WIDTH-1:0] den;
    bit             typed;
    bit [WIDTH-1:0] want_num;
    bit [WIDTH-1:0] want_den;
  } table_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [DATA_W-1:0] out_tdata;

  fraction_t expected_lowest_terms[$];
  int        mismatch_count = 0;
  int        quiet_cycles = 0;
  int        send_idle_pct;
  int        recv_idle_pct;
  bit        hold_request = 1'b0;

  // Rows with typed set carry their expected result written out in the table.
  table_row_t stimulus_table [0:TABLE_ROWS-1] = '{
    '{64'd0, 64'd0, 1'b1, 64'd0, 64'd0},
    '{64'd0, 64'd1, 1'b1, 64'd0, 64'd1},
    '{64'd0, 64'd6, 1'b1, 64'd0, 64'd1},
    '{64'd0, ALL_ONES, 1'b1, 64'd0, 64'd1},
    '{ALL_ONES, 64'd1, 1'b1, ALL_ONES, 64'd1},
    '{64'd9, 64'd1, 1'b1, 64'd9, 64'd1},
    '{64'd1, 64'd1, 1'b1, 64'd1, 64'd1},
    '{64'd5, 64'd5, 1'b1, 64'd1, 64'd1},
    '{ALL_ONES, ALL_ONES, 1'b1, 64'd1, 64'd1},
    '{TOP_BIT, TOP_BIT, 1'b1, 64'd1, 64'd1},
    '{64'd12, 64'd0, 1'b1, 64'd1, 64'd0},
    '{ALL_ONES, 64'd0, 1'b1, 64'd1, 64'd0},
    '{64'd1, 64'd0, 1'b1, 64'd1, 64'd0},
    '{64'd1, ALL_ONES, 1'b1, 64'd1, ALL_ONES},
    '{ALL_ONES, 64'd2, 1'b1, ALL_ONES, 64'd2},
    '{64'd6, 64'd4, 1'b0, 64'd0, 64'd0},
    '{TOP_BIT, 64'h4000_0000_0000_0000, 1'b0, 64'd0, 64'd0},
    '{64'hFFFF_FFFF_FFFF_FFFE, ALL_ONES, 1'b0, 64'd0, 64'd0},
    '{ALL_ONES, 64'd3, 1'b0, 64'd0, 64'd0},
    '{64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFC4, 1'b0, 64'd0, 64'd0},
    '{64'd2, TOP_BIT, 1'b0, 64'd0, 64'd0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, 64'd0, 64'd0}
  };

  fraction_reducer_unit #(.WIDTH(WIDTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic fraction_t reduce_fraction(input fraction_t f);
    bit [WIDTH-1:0] a;
    bit [WIDTH-1:0] b;
    bit [WIDTH-1:0] r;
    if (f.den == 1) begin
      return f;
    end
    if (f.num == 0) begin
      if (f.den != 0) f.den = 1;
      return f;
    end
    if (f.num == f.den) begin
      f.num = 1;
      f.den = 1;
      return f;
    end
    // Euclid; with a zero denominator the divisor is the numerator itself.
    a = f.num;
    b = f.den;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    if (a > 1) begin
      f.num = f.num / a;
      f.den = f.den / a;
    end
    return f;
  endfunction

  function automatic bit [WIDTH-1:0] random_bits(input int bits);
    bit [63:0] raw;
    raw = {$urandom, $urandom};
    return WIDTH'(raw >> (64 - bits));
  endfunction

  // Nearly half the requests share a factor wide enough to keep the GCD loop busy;
  // the rest hit the shortcuts, have a zero denominator or are plain random pairs.
  function automatic fraction_t random_fraction();
    fraction_t      f;
    bit [WIDTH-1:0] g;
    int             pick;
    pick = $urandom_range(99);
    f.num = random_bits($urandom_range(1, WIDTH));
    f.den = random_bits($urandom_range(1, WIDTH));
    if (pick < 45) begin
      g = random_bits($urandom_range(1, WIDTH / 2));
      f.num = random_bits($urandom_range(1, WIDTH / 2)) * g;
      f.den = random_bits($urandom_range(1, WIDTH / 2)) * g;
    end else if (pick < 55) begin
      f.den = 1;
    end else if (pick < 63) begin
      f.num = 0;
    end else if (pick < 70) begin
      f.den = f.num;
    end else if (pick < 76) begin
      f.den = 0;
    end
    return f;
  endfunction

  task automatic flag_mismatch(input string what, input bit [WIDTH-1:0] got,
                               input bit [WIDTH-1:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Leaves in_tvalid high after the request is taken; the next call lowers it or
  // drives new data, the end of stimulus lowers it; never two updates in one step.
  task automatic send_fraction(input fraction_t f, input fraction_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= f;
    do @(posedge clk); while (!in_tready);
    expected_lowest_terms.push_back(want);
  endtask

  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    fraction_t got;
    fraction_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_lowest_terms.size() == 0) begin
        // Nothing was outstanding, so any result is one too many.
        flag_mismatch("unexpected result, numerator", got.num, '0);
      end else begin
        want = expected_lowest_terms.pop_front();
        if (got.num != want.num) flag_mismatch("reduced_numerator", got.num, want.num);
        if (got.den != want.den) flag_mismatch("reduced_denominator", got.den, want.den);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("TIMEOUT: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    fraction_t f;
    fraction_t want;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    send_idle_pct = 7;
    recv_idle_pct = 87;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stimulus_table[i]) begin
      f.num = stimulus_table[i].num;
      f.den = stimulus_table[i].den;
      if (stimulus_table[i].typed) begin
        want.num = stimulus_table[i].want_num;
        want.den = stimulus_table[i].want_den;
      end else begin
        want = reduce_fraction(f);
      end
      send_fraction(f, want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 87 : 0;
      recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 7 : 0;
      // The long receiver hold-off lets the queue fill and in_tready drop.
      if (phase == 2) hold_request = 1'b1;
      repeat (RANDOM_PER_PHASE) begin
        f = random_fraction();
        send_fraction(f, reduce_fraction(f));
      end
    end
    in_tvalid <= 1'b0;

    while (expected_lowest_terms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== fraction_reducer_unit.f =====
hw/rtl/frac_pkg.sv
hw/rtl/frac_front.sv
hw/rtl/frac_queue.sv
hw/rtl/frac_back.sv
hw/rtl/fraction_reducer_unit.sv
dv/tb_fraction_reducer_unit.sv
